// File: rtl/core/voxel_face_cull_mesher_unit_defines.svh
// Assertion macros used by the vfcm_emit module.
`ifndef VOXEL_FACE_CULL_MESHER_UNIT_DEFINES_SVH
`define VOXEL_FACE_CULL_MESHER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define VFCM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define VFCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/vfcm_pkg.sv
package vfcm_pkg;

    localparam int EDGE_LEN = 32;
    localparam int COORD_W  = 5;
    localparam int CLS_W    = 3;
    localparam int CNT_W    = 20;
    localparam int POS_W    = 16;
    localparam int OFF_W    = 11;
    localparam int QUAD_NUM = 9;
    localparam int QUAD_W   = 4;

    // block classes
    localparam logic [CLS_W-1:0] CLS_AIR    = 3'd0;
    localparam logic [CLS_W-1:0] CLS_OPAQUE = 3'd1;
    localparam logic [CLS_W-1:0] CLS_TRANSP = 3'd2;
    localparam logic [CLS_W-1:0] CLS_LEAVES = 3'd3;
    localparam logic [CLS_W-1:0] CLS_BILL   = 3'd4;
    localparam logic [CLS_W-1:0] CLS_LIQ    = 3'd5;

    // target meshes
    localparam logic [1:0] MESH_SOLID = 2'd0;
    localparam logic [1:0] MESH_FLUID = 2'd1;
    localparam logic [1:0] MESH_BILL  = 2'd2;

    // texture rectangles
    localparam logic [1:0] UV_SIDE   = 2'd0;
    localparam logic [1:0] UV_BOTTOM = 2'd1;
    localparam logic [1:0] UV_TOP    = 2'd2;

    // face directions
    localparam logic [2:0] FACE_NORTH  = 3'd0;
    localparam logic [2:0] FACE_SOUTH  = 3'd1;
    localparam logic [2:0] FACE_WEST   = 3'd2;
    localparam logic [2:0] FACE_EAST   = 3'd3;
    localparam logic [2:0] FACE_BOTTOM = 3'd4;
    localparam logic [2:0] FACE_TOP    = 3'd5;
    localparam logic [2:0] FACE_BILL   = 3'd6;

    // quads in emission order; also the bit positions of the quad mask
    typedef enum logic [QUAD_W-1:0] {
        Q_NORTH  = 4'd0,
        Q_SOUTH  = 4'd1,
        Q_EAST   = 4'd2,
        Q_WEST   = 4'd3,
        Q_BOTTOM = 4'd4,
        Q_TOP    = 4'd5,
        Q_TOP2   = 4'd6,
        Q_BB1    = 4'd7,
        Q_BB2    = 4'd8
    } quad_t;

    localparam logic [OFF_W-1:0] ONE_Q   = 11'd1024;
    localparam logic [OFF_W-1:0] DIAG_HI = 11'd874;
    localparam logic [OFF_W-1:0] DIAG_LO = 11'd150;
    localparam logic [OFF_W-1:0] ZQ      = 11'd0;

    // corner offsets [quad][vertex][x,y,z]
    localparam logic [OFF_W-1:0] QUAD_OFF [0:QUAD_NUM-1][0:3][0:2] = '{
        '{'{ONE_Q, ZQ, ZQ}, '{ZQ, ZQ, ZQ}, '{ONE_Q, ONE_Q, ZQ}, '{ZQ, ONE_Q, ZQ}},
        '{'{ZQ, ZQ, ONE_Q}, '{ONE_Q, ZQ, ONE_Q}, '{ZQ, ONE_Q, ONE_Q},
          '{ONE_Q, ONE_Q, ONE_Q}},
        '{'{ONE_Q, ZQ, ONE_Q}, '{ONE_Q, ZQ, ZQ}, '{ONE_Q, ONE_Q, ONE_Q},
          '{ONE_Q, ONE_Q, ZQ}},
        '{'{ZQ, ZQ, ZQ}, '{ZQ, ZQ, ONE_Q}, '{ZQ, ONE_Q, ZQ}, '{ZQ, ONE_Q, ONE_Q}},
        '{'{ONE_Q, ZQ, ONE_Q}, '{ZQ, ZQ, ONE_Q}, '{ONE_Q, ZQ, ZQ}, '{ZQ, ZQ, ZQ}},
        '{'{ZQ, ONE_Q, ONE_Q}, '{ONE_Q, ONE_Q, ONE_Q}, '{ZQ, ONE_Q, ZQ},
          '{ONE_Q, ONE_Q, ZQ}},
        '{'{ONE_Q, ONE_Q, ONE_Q}, '{ZQ, ONE_Q, ONE_Q}, '{ONE_Q, ONE_Q, ZQ},
          '{ZQ, ONE_Q, ZQ}},
        '{'{DIAG_HI, ZQ, DIAG_HI}, '{DIAG_LO, ZQ, DIAG_LO},
          '{DIAG_HI, ONE_Q, DIAG_HI}, '{DIAG_LO, ONE_Q, DIAG_LO}},
        '{'{DIAG_LO, ZQ, DIAG_HI}, '{DIAG_HI, ZQ, DIAG_LO},
          '{DIAG_LO, ONE_Q, DIAG_HI}, '{DIAG_HI, ONE_Q, DIAG_LO}}
    };

    // one decoded voxel, waiting to be expanded into vertices
    typedef struct packed {
        logic                clr;
        logic [QUAD_NUM-1:0] mask;
        logic [1:0]          mesh;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  z;
        logic                wt;
    } item_t;

    typedef struct packed {
        logic [1:0]       mesh_sel;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_z;
        logic [1:0]       uv_set;
        logic             u_corner;
        logic             v_corner;
        logic [2:0]       face_dir;
        logic             water_top;
        logic [CNT_W-1:0] vertex_index;
        logic             last;
    } vertex_t;

endpackage

// File: rtl/core/vfcm_decode.sv
module vfcm_decode
    import vfcm_pkg::*;
(
    input  logic               action,
    input  logic [COORD_W-1:0] vox_x,
    input  logic [COORD_W-1:0] vox_y,
    input  logic [COORD_W-1:0] vox_z,
    input  logic [CLS_W-1:0]   self_class,
    input  logic [CLS_W-1:0]   above_class,
    input  logic [CLS_W-1:0]   below_class,
    input  logic [CLS_W-1:0]   north_class,
    input  logic [CLS_W-1:0]   south_class,
    input  logic [CLS_W-1:0]   east_class,
    input  logic [CLS_W-1:0]   west_class,
    output item_t              item
);

    localparam logic [COORD_W:0] COORD_MAX = (COORD_W+1)'(EDGE_LEN - 1);

    function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] c);
        logic [COORD_W:0] ce;
        ce = {1'b0, c};
        if (ce > COORD_MAX)
            return COORD_MAX[COORD_W-1:0];
        return c;
    endfunction

    // undefined classes hide the face like opaque
    function automatic logic exposed(input logic [CLS_W-1:0] nb, input logic liq);
        return (nb == CLS_AIR) || (nb == CLS_TRANSP) || (nb == CLS_LEAVES) ||
               (nb == CLS_BILL) || ((nb == CLS_LIQ) && !liq);
    endfunction

    logic liq;
    logic solid_like;
    logic bill;

    always_comb
    begin
        liq        = (self_class == CLS_LIQ);
        bill       = (self_class == CLS_BILL);
        solid_like = (self_class == CLS_OPAQUE) || (self_class == CLS_TRANSP) ||
                     (self_class == CLS_LEAVES) || liq;

        item      = '0;
        item.clr  = action;
        item.x    = clamp(vox_x);
        item.y    = clamp(vox_y);
        item.z    = clamp(vox_z);
        item.wt   = liq && ((above_class == CLS_TRANSP) || (above_class == CLS_AIR));
        item.mesh = bill ? MESH_BILL : (liq ? MESH_FLUID : MESH_SOLID);

        if (!action && bill)
        begin
            item.mask[Q_BB1] = 1'b1;
            item.mask[Q_BB2] = 1'b1;
        end
        else if (!action && solid_like)
        begin
            item.mask[Q_NORTH]  = exposed(north_class, liq);
            item.mask[Q_SOUTH]  = exposed(south_class, liq);
            item.mask[Q_EAST]   = exposed(east_class, liq);
            item.mask[Q_WEST]   = exposed(west_class, liq);
            item.mask[Q_BOTTOM] = exposed(below_class, liq);
            if (liq)
            begin
                // liquid surface: both windings
                item.mask[Q_TOP]  = (above_class != CLS_LIQ);
                item.mask[Q_TOP2] = (above_class != CLS_LIQ);
            end
            else
            begin
                item.mask[Q_TOP] = exposed(above_class, 1'b0);
            end
        end
    end

endmodule

// File: rtl/core/vfcm_emit.sv
`include "voxel_face_cull_mesher_unit_defines.svh"

module vfcm_emit
    import vfcm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   in_item,
    output logic    out_valid,
    input  logic    out_ready,
    output vertex_t out_vtx
);

    item_t               item_reg;
    logic                item_valid_reg;
    logic [1:0]          vert_k_reg;
    logic [CNT_W-1:0]    solid_cnt_reg;
    logic [CNT_W-1:0]    fluid_cnt_reg;
    logic [CNT_W-1:0]    bill_cnt_reg;
    logic                out_valid_reg;
    vertex_t             out_reg;

    quad_t               quad_sel;
    logic [QUAD_NUM-1:0] mask_rest;
    logic                advance;
    logic                emit_fire;
    logic                item_done;
    logic                in_fire;
    logic [CNT_W-1:0]    cur_cnt;
    vertex_t             vtx_next;

    always_comb
    begin
        quad_sel = Q_NORTH;
        for (int i = QUAD_NUM - 1; i >= 0; i--)
        begin
            if (item_reg.mask[i])
                quad_sel = quad_t'(QUAD_W'(i));
        end
    end

    assign mask_rest = item_reg.mask & (item_reg.mask - QUAD_NUM'(1));
    assign advance   = !out_valid_reg || out_ready;
    assign emit_fire = advance && item_valid_reg && !item_reg.clr && (item_reg.mask != '0);
    // clear and empty items retire without waiting for the output side
    assign item_done = item_valid_reg &&
                       (item_reg.clr || (item_reg.mask == '0) ||
                        (advance && (vert_k_reg == 2'd3) && (mask_rest == '0)));
    assign in_ready  = !item_valid_reg || item_done;
    assign in_fire   = in_valid && in_ready;

    always_comb
    begin
        case (item_reg.mesh)
            MESH_SOLID: cur_cnt = solid_cnt_reg;
            MESH_FLUID: cur_cnt = fluid_cnt_reg;
            default:    cur_cnt = bill_cnt_reg;
        endcase
    end

    always_comb
    begin
        vtx_next              = '0;
        vtx_next.mesh_sel     = item_reg.mesh;
        vtx_next.pos_x        = {1'b0, item_reg.x, 10'b0} +
                                POS_W'(QUAD_OFF[quad_sel][vert_k_reg][0]);
        vtx_next.pos_y        = {1'b0, item_reg.y, 10'b0} +
                                POS_W'(QUAD_OFF[quad_sel][vert_k_reg][1]);
        vtx_next.pos_z        = {1'b0, item_reg.z, 10'b0} +
                                POS_W'(QUAD_OFF[quad_sel][vert_k_reg][2]);
        vtx_next.u_corner     = vert_k_reg[0];
        vtx_next.v_corner     = vert_k_reg[1];
        vtx_next.vertex_index = cur_cnt;
        vtx_next.last         = (vert_k_reg == 2'd3) && (mask_rest == '0);
        case (quad_sel) inside
            Q_BOTTOM:     vtx_next.uv_set = UV_BOTTOM;
            Q_TOP, Q_TOP2: vtx_next.uv_set = UV_TOP;
            default:      vtx_next.uv_set = UV_SIDE;
        endcase
        case (quad_sel) inside
            Q_NORTH:      vtx_next.face_dir = FACE_NORTH;
            Q_SOUTH:      vtx_next.face_dir = FACE_SOUTH;
            Q_EAST:       vtx_next.face_dir = FACE_EAST;
            Q_WEST:       vtx_next.face_dir = FACE_WEST;
            Q_BOTTOM:     vtx_next.face_dir = FACE_BOTTOM;
            Q_TOP, Q_TOP2: vtx_next.face_dir = FACE_TOP;
            default:      vtx_next.face_dir = FACE_BILL;
        endcase
        // side faces flag only their upper edge
        case (quad_sel) inside
            Q_NORTH, Q_SOUTH, Q_EAST, Q_WEST: vtx_next.water_top = item_reg.wt && vert_k_reg[1];
            Q_TOP, Q_TOP2:                    vtx_next.water_top = item_reg.wt;
            default:                          vtx_next.water_top = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            vert_k_reg     <= 2'd0;
            solid_cnt_reg  <= '0;
            fluid_cnt_reg  <= '0;
            bill_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                item_valid_reg <= 1'b1;
                vert_k_reg     <= 2'd0;
            end
            else if (item_done)
            begin
                item_valid_reg <= 1'b0;
            end
            else if (emit_fire)
            begin
                vert_k_reg <= vert_k_reg + 2'd1;
            end

            if (item_valid_reg && item_reg.clr)
            begin
                solid_cnt_reg <= '0;
                fluid_cnt_reg <= '0;
                bill_cnt_reg  <= '0;
            end
            else if (emit_fire)
            begin
                case (item_reg.mesh)
                    MESH_SOLID: solid_cnt_reg <= solid_cnt_reg + CNT_W'(1);
                    MESH_FLUID: fluid_cnt_reg <= fluid_cnt_reg + CNT_W'(1);
                    default:    bill_cnt_reg  <= bill_cnt_reg + CNT_W'(1);
                endcase
            end

            if (advance)
                out_valid_reg <= emit_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            item_reg <= in_item;
        else if (emit_fire && (vert_k_reg == 2'd3))
            item_reg.mask <= mask_rest;

        if (emit_fire)
            out_reg <= vtx_next;
    end

    assign out_valid = out_valid_reg;
    assign out_vtx   = out_reg;

    `VFCM_ASSERT_NEXT(a_clear_zeroes, clk, rst_n, item_valid_reg && item_reg.clr,
        (solid_cnt_reg == '0) && (fluid_cnt_reg == '0) && (bill_cnt_reg == '0),
        "vertex counters not cleared")
    `VFCM_ASSERT_NEXT(a_solid_inc, clk, rst_n, emit_fire && (item_reg.mesh == MESH_SOLID),
        solid_cnt_reg == $past(solid_cnt_reg) + CNT_W'(1), "solid counter did not advance")
    `VFCM_ASSERT_NEXT(a_last_flag, clk, rst_n,
        emit_fire && (vert_k_reg == 2'd3) && $onehot(item_reg.mask),
        out_valid_reg && out_reg.last, "final vertex not marked last")
    `VFCM_ASSERT_NOW(a_bill_quads, clk, rst_n, item_valid_reg && (item_reg.mesh == MESH_BILL),
        item_reg.mask[Q_BB1-1:0] == '0, "billboard item carries face quads")

endmodule

// File: rtl/core/voxel_face_cull_mesher_unit.sv
// The first vertex of an accepted voxel passes through the item register, then the output register.
// Throughput: one vertex per cycle while m_tready does not stall the output; a voxel emits four
// vertices per emitted quad (at most 28 vertices), a counter clear or an air voxel none.
// The next voxel is accepted in the cycle the previous voxel's final vertex issues.
// Reset: all three vertex counters go to zero and the pipeline empties.
module voxel_face_cull_mesher_unit
    import vfcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // vox_x, vox_y, vox_z, self_class, above_class, below_class, north_class,
    // south_class, east_class, west_class, zero pad
    input  logic [39:0] s_tdata,
    // action
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pos_x, pos_y, pos_z, uv_set, u_corner, v_corner, face_dir, water_top,
    // vertex_index, zero pad
    output logic [79:0] m_tdata,
    // mesh_sel
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    item_t   item;
    vertex_t vtx;

    vfcm_decode u_decode (
        .action      (s_tuser[0]),
        .vox_x       (s_tdata[4:0]),
        .vox_y       (s_tdata[9:5]),
        .vox_z       (s_tdata[14:10]),
        .self_class  (s_tdata[17:15]),
        .above_class (s_tdata[20:18]),
        .below_class (s_tdata[23:21]),
        .north_class (s_tdata[26:24]),
        .south_class (s_tdata[29:27]),
        .east_class  (s_tdata[32:30]),
        .west_class  (s_tdata[35:33]),
        .item        (item)
    );

    vfcm_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_vtx   (vtx)
    );

    assign m_tdata = {4'b0, vtx.vertex_index, vtx.water_top, vtx.face_dir, vtx.v_corner,
                      vtx.u_corner, vtx.uv_set, vtx.pos_z, vtx.pos_y, vtx.pos_x};
    assign m_tuser = vtx.mesh_sel;
    assign m_tlast = vtx.last;

endmodule
